### src/lrws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrws_pkg
// Shared constants, codes and control types of the least-recent window
// scheduler.
// ----------------------------------------------------------------------------
package lrws_pkg;

	localparam int WINDOWS   = 64;
	localparam int RECEIVERS = 8;
	localparam int TIME_BITS = 32;

	// internal widths
	localparam int WIN_W = $clog2(WINDOWS);
	localparam int CNT_W = $clog2(WINDOWS + 1);
	localparam int RX_W  = (RECEIVERS > 1) ? $clog2(RECEIVERS) : 1;

	// fixed field widths
	localparam int OP_FW  = 2;
	localparam int RX_FW  = 3;
	localparam int WIN_FW = 6;
	localparam int TS_FW  = 32;
	localparam int CNT_FW = 7;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 8;

	typedef enum logic [OP_FW-1:0] {
		OP_REQUEST = 2'd0,
		OP_DONE    = 2'd1,
		OP_REBUILD = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;    // capture the incoming transaction
		logic scan;    // walk the window table
		logic commit;  // apply updates and load the result register
	} cmd_t;

	typedef struct packed {
		logic scan_end;  // search finished (or nothing to search)
		logic out_free;  // result register can take a new result
	} sts_t;

endpackage

### src/lrws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrws_ctrl
// Sequencer: accept, scan, commit.
// ----------------------------------------------------------------------------
module lrws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  lrws_pkg::sts_t sts,
	output lrws_pkg::cmd_t cmd
);
	import lrws_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FINISH: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

### src/lrws_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrws_datapath
// Window time table, receiver state, oldest-window search, result register.
// ----------------------------------------------------------------------------
module lrws_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lrws_pkg::cmd_t                  cmd,
	output lrws_pkg::sts_t                  sts,
	input  logic [lrws_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [lrws_pkg::OP_FW-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lrws_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [0:0]                      m_tuser
);
	import lrws_pkg::*;

	// captured transaction
	logic [OP_FW-1:0]  op_q;
	logic [RX_FW-1:0]  rx_q;
	logic [WIN_FW-1:0] win_q;
	logic [TS_FW-1:0]  ts_q;
	logic [CNT_FW-1:0] cnt_q;

	// block state
	logic [TIME_BITS-1:0] mem [WINDOWS];
	logic [WINDOWS-1:0]   tvalid_q;      // entry stamped since rebuild
	logic [WIN_W-1:0]     rwin_q [RECEIVERS];
	logic [RECEIVERS-1:0] busy_q;
	logic [CNT_W-1:0]     in_use_q;

	// search
	logic [CNT_W-1:0]     ptr_q;
	logic                 rd_vld_s1;
	logic [WIN_W-1:0]     idx_s1;
	logic                 held_s1;
	logic                 stamped_s1;
	logic [TIME_BITS-1:0] rd_data_s1;
	logic                 found_q;
	logic [WIN_W-1:0]     best_q;
	logic [TIME_BITS-1:0] best_t_q;

	// result register
	logic             out_vld_q;
	logic             out_grant_q;
	logic [WIN_W-1:0] out_win_q;

	logic                 rx_ok;
	logic                 scan_req;
	logic                 issue;
	logic                 held;
	logic [TIME_BITS-1:0] cur_t;
	logic                 grant;
	logic                 stamp;
	logic [RX_W-1:0]      rx_idx;

	assign rx_ok    = int'(rx_q) < RECEIVERS;
	assign rx_idx   = rx_q[RX_W-1:0];
	assign scan_req = (op_q == OP_REQUEST) && rx_ok;
	assign issue    = cmd.scan && scan_req && (ptr_q < in_use_q);
	assign cur_t    = stamped_s1 ? rd_data_s1 : '0;
	assign grant    = scan_req && found_q;
	assign stamp    = cmd.commit && (op_q == OP_DONE) && rx_ok && busy_q[rx_idx]
		&& ({1'b0, win_q} < CNT_FW'(in_use_q));

	assign sts.scan_end = !scan_req || ((ptr_q >= in_use_q) && !rd_vld_s1);
	assign sts.out_free = !out_vld_q || m_tready;

	// is the window under the pointer held by some receiver
	always_comb begin
		held = 1'b0;
		for (int r = 0; r < RECEIVERS; r++) begin
			if (busy_q[r] && (rwin_q[r] == ptr_q[WIN_W-1:0])) begin
				held = 1'b1;
			end
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rx_q  <= s_tdata[2:0];
			win_q <= s_tdata[8:3];
			ts_q  <= s_tdata[40:9];
			cnt_q <= s_tdata[47:41];
			op_q  <= s_tuser;
		end
	end

	// time table
	always_ff @(posedge clk) begin
		if (stamp) begin
			mem[win_q[WIN_W-1:0]] <= ts_q[TIME_BITS-1:0];
		end
		rd_data_s1 <= mem[ptr_q[WIN_W-1:0]];
	end

	// payload side of the search and receiver windows
	always_ff @(posedge clk) begin
		idx_s1     <= ptr_q[WIN_W-1:0];
		held_s1    <= held;
		stamped_s1 <= tvalid_q[ptr_q[WIN_W-1:0]];
		if (rd_vld_s1 && !held_s1 && (!found_q || (cur_t < best_t_q))) begin
			best_q   <= idx_s1;
			best_t_q <= cur_t;
		end
		if (cmd.commit && grant) begin
			rwin_q[rx_idx] <= best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q    <= '0;
			busy_q      <= '0;
			in_use_q    <= '0;
			ptr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_vld_q   <= 1'b0;
			out_grant_q <= 1'b0;
			out_win_q   <= '0;
		end else begin
			if (cmd.load) begin
				ptr_q     <= '0;
				rd_vld_s1 <= 1'b0;
				found_q   <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (rd_vld_s1 && !held_s1) begin
					found_q <= 1'b1;
				end
			end

			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end

			if (cmd.commit) begin
				out_vld_q   <= 1'b1;
				out_grant_q <= grant;
				out_win_q   <= grant ? best_q : '0;
				case (op_q)
					OP_REQUEST: begin
						if (grant) begin
							busy_q[rx_idx] <= 1'b1;
						end
					end
					OP_DONE: begin
						if (rx_ok) begin
							busy_q[rx_idx] <= 1'b0;
						end
						if (stamp) begin
							tvalid_q[win_q[WIN_W-1:0]] <= 1'b1;
						end
					end
					OP_REBUILD: begin
						tvalid_q <= '0;
						busy_q   <= '0;
						in_use_q <= (cnt_q > CNT_FW'(WINDOWS)) ? CNT_W'(WINDOWS)
							: CNT_W'(cnt_q);
					end
					default: begin
						out_grant_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = M_TDATA_W'(out_win_q);
	assign m_tuser  = out_grant_q;

	// checks
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CNT_W'(idx_s1) < in_use_q))
		else $error("search read beyond windows in use");

	a_commit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !rd_vld_s1)
		else $error("commit while search read in flight");

	a_rebuild_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (op_q == OP_REBUILD)) |=> ((busy_q == '0) && (tvalid_q == '0)))
		else $error("rebuild left receivers busy or times set");

	a_in_use_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q <= CNT_W'(WINDOWS))
		else $error("window count above table size");

	a_grant_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && grant) |=> (out_grant_q && busy_q[$past(rx_idx)]))
		else $error("grant without receiver marked busy");

endmodule

### src/least_recent_window_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_recent_window_scheduler
// Assigns to a requesting receiver the free window with the oldest scan time.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                                   | tuser
//  s_*     | in  | receiver_index 3, window_index 6, time_stamp 32,     | operation 2
//          |     | window_count 7                                       |
//  m_*     | out | granted_window 6, 2 zero bits                        | granted 1
//
//  A request on a non-empty table searches the windows in use, reading one
//  time-table entry per cycle; done, rebuild and unknown items, and requests
//  on an empty table, skip the search. The next transaction can be accepted at
//  the same edge as the earliest result handshake.
//  One transaction in flight; s_tready is high only in the idle state.
//  A result waiting in the output register does not block acceptance; the
//  next result waits for it to be taken. Reset clears all times, frees all
//  receivers and sets the window count to zero, with no clearing pass.
// ----------------------------------------------------------------------------
module least_recent_window_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// receiver_index, window_index, time_stamp, window_count
	input  logic [lrws_pkg::S_TDATA_W-1:0] s_tdata,
	// operation
	input  logic [lrws_pkg::OP_FW-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// granted_window, zero pad
	output logic [lrws_pkg::M_TDATA_W-1:0] m_tdata,
	// granted
	output logic [0:0]                     m_tuser
);
	import lrws_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: idle -> scan (walks windows for requests) -> finish (commit)
	lrws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tables, search and the output register
	lrws_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
